// ----- sv/mip_pkg.sv -----
// Package for the 68000 instruction predecode unit.
// Holds the match table, the class codes and the special opcode constants.
// Depends on nothing; mip_classify, mip_ext_count and the top unit use it.
`default_nettype none

package mip_pkg;

    localparam int unsigned NUM_CLASSES = 42;
    localparam int unsigned CLASS_W     = 6;
    localparam int unsigned EXT_W       = 3;
    localparam int unsigned ADDR_W      = 24;
    localparam int unsigned OP_W        = 16;

    // Largest extension word count any instruction can have.
    localparam logic [EXT_W-1:0] MAX_EXT = 3'd4;

    // Source field value that selects an immediate operand.
    localparam logic [5:0]  IMM_EA  = 6'h3c;
    localparam logic [15:0] OP_STOP = 16'h4e72;
    localparam logic [15:0] OP_RTD  = 16'h4e74;

    typedef logic [CLASS_W-1:0] t_class;
    typedef logic [EXT_W-1:0]   t_ext;

    // Class codes: the index of the table entry that matched.
    localparam t_class CLS_SHIFT_MEM = 6'd3;
    localparam t_class CLS_DBCC      = 6'd5;
    localparam t_class CLS_BCC       = 6'd6;
    localparam t_class CLS_LINK      = 6'd15;
    localparam t_class CLS_CTRL      = 6'd17;
    localparam t_class CLS_MOVEP     = 6'd18;
    localparam t_class CLS_BIT_IMM   = 6'd19;
    localparam t_class CLS_BIT_DYN   = 6'd20;
    localparam t_class CLS_IMM_OP    = 6'd21;
    localparam t_class CLS_MOVE      = 6'd22;
    localparam t_class CLS_ADDR_OP   = 6'd23;
    localparam t_class CLS_MULDIV    = 6'd26;
    localparam t_class CLS_CMP_EOR   = 6'd27;
    localparam t_class CLS_ALU       = 6'd28;
    localparam t_class CLS_SCC       = 6'd29;
    localparam t_class CLS_QUICK     = 6'd30;
    localparam t_class CLS_MOVEM     = 6'd31;
    localparam t_class CLS_MOVE_SR   = 6'd32;
    localparam t_class CLS_MOVE_FSR  = 6'd33;
    localparam t_class CLS_LEA       = 6'd34;
    localparam t_class CLS_TAS       = 6'd35;
    localparam t_class CLS_CHK       = 6'd36;
    localparam t_class CLS_JUMP      = 6'd37;
    localparam t_class CLS_NBCD      = 6'd38;
    localparam t_class CLS_PEA       = 6'd39;
    localparam t_class CLS_UNARY     = 6'd40;
    localparam t_class CLS_CATCH_ALL = 6'd41;

    typedef logic [OP_W-1:0] t_word_table [NUM_CLASSES];

    // Match masks, in priority order; the last entry matches anything.
    localparam t_word_table MATCH_MASK = '{
        16'hfff8, 16'hffff, 16'hf100, 16'hf8c0, 16'hf000, 16'hf0f8, 16'hf000, 16'hf1f8,
        16'hf1f8, 16'hf1f8, 16'hb1f0, 16'hfff0, 16'hffb8, 16'hfff0, 16'hfff8, 16'hfff8,
        16'hfff8, 16'hfff8, 16'hf138, 16'hff00, 16'hf100, 16'hf100, 16'hc000, 16'h90c0,
        16'hf138, 16'hb130, 16'hb0c0, 16'hf100, 16'h8000, 16'hf0c0, 16'hf000, 16'hfb80,
        16'hfdc0, 16'hfdc0, 16'hf1c0, 16'hffc0, 16'hf1c0, 16'hff80, 16'hffc0, 16'hffc0,
        16'hf100, 16'h0000
    };

    // Match keys, paired with the masks above.
    localparam t_word_table MATCH_KEY = '{
        16'h4848, 16'h4afc, 16'h7000, 16'he0c0, 16'he000, 16'h50c8, 16'h6000, 16'hc140,
        16'hc148, 16'hc188, 16'h8100, 16'h4e60, 16'h4880, 16'h4e40, 16'h4840, 16'h4e50,
        16'h4e58, 16'h4e70, 16'h0108, 16'h0800, 16'h0100, 16'h0000, 16'h0000, 16'h90c0,
        16'hb108, 16'h9100, 16'h80c0, 16'hb100, 16'h8000, 16'h50c0, 16'h5000, 16'h4880,
        16'h44c0, 16'h40c0, 16'h41c0, 16'h4ac0, 16'h4180, 16'h4e80, 16'h4800, 16'h4840,
        16'h4000, 16'h0000
    };

endpackage

`default_nettype wire

// ----- sv/mip_ifs.sv -----
// Handshake interfaces for the predecode unit: request and response channels.
// Each carries valid, ready and the payload; depends on nothing else.
`default_nettype none

interface mip_req_if;
    logic        valid;
    logic        ready;
    logic [15:0] opcode_word;
    logic [23:0] instr_address;

    modport source (output valid, output opcode_word, output instr_address, input ready);
    modport sink   (input valid, input opcode_word, input instr_address, output ready);
endinterface

interface mip_rsp_if;
    logic        valid;
    logic        ready;
    logic [5:0]  instr_class;
    logic [2:0]  extension_words;
    logic [23:0] next_address;

    modport source (output valid, output instr_class, output extension_words,
                    output next_address, input ready);
    modport sink   (input valid, input instr_class, input extension_words,
                    input next_address, output ready);
endinterface

`default_nettype wire

// ----- sv/mip_classify.sv -----
// Priority match of an opcode word against the mask/key table.
// Depends on mip_pkg for the table and the class type.
`default_nettype none

module mip_classify (
    input  wire logic [15:0]     i_opcode,
    output mip_pkg::t_class      o_class
);

    // Every entry is compared in parallel; the lowest matching index wins.
    always_comb begin
        o_class = mip_pkg::CLS_CATCH_ALL;
        for (int i = mip_pkg::NUM_CLASSES - 1; i >= 0; i--) begin
            if ((i_opcode & mip_pkg::MATCH_MASK[i]) == mip_pkg::MATCH_KEY[i]) begin
                o_class = mip_pkg::t_class'(i);
            end
        end
    end

endmodule

`default_nettype wire

// ----- sv/mip_ext_count.sv -----
// Extension word count for one classified opcode word.
// Depends on mip_pkg for the class codes and special opcode constants.
`default_nettype none

module mip_ext_count (
    input  wire logic [15:0]     i_opcode,
    input  mip_pkg::t_class      i_class,
    output mip_pkg::t_ext        o_ext
);

    // Words taken by one effective address, from its mode and register fields.
    function automatic logic [1:0] ea_words(input logic [2:0] mode, input logic [2:0] rg);
        logic [1:0] w;
        w = 2'd0;
        if (mode == 3'd5 || mode == 3'd6) begin
            w = 2'd1;
        end else if (mode == 3'd7) begin
            if (rg == 3'd1) begin
                w = 2'd2;
            end else if (rg == 3'd0 || rg == 3'd2 || rg == 3'd3) begin
                w = 2'd1;
            end
        end
        return w;
    endfunction

    logic [1:0] src_words;
    logic [1:0] dst_words;
    logic       imm;
    logic [1:0] move_src;

    assign src_words = ea_words(i_opcode[5:3], i_opcode[2:0]);
    assign dst_words = ea_words(i_opcode[8:6], i_opcode[11:9]);
    assign imm       = (i_opcode[5:0] == mip_pkg::IMM_EA);
    // A move immediate is one word for byte and word size, two otherwise.
    assign move_src  = imm ? (i_opcode[12] ? 2'd1 : 2'd2) : src_words;

    // Count selected by class; most classes need only the source address.
    always_comb begin
        unique case (i_class)
            mip_pkg::CLS_DBCC, mip_pkg::CLS_LINK, mip_pkg::CLS_MOVEP: begin
                o_ext = 3'd1;
            end
            mip_pkg::CLS_BCC: begin
                o_ext = (i_opcode[7:0] == 8'd0) ? 3'd1 : 3'd0;
            end
            mip_pkg::CLS_CTRL: begin
                o_ext = (i_opcode == mip_pkg::OP_STOP || i_opcode == mip_pkg::OP_RTD)
                        ? 3'd1 : 3'd0;
            end
            mip_pkg::CLS_BIT_IMM, mip_pkg::CLS_MOVEM: begin
                o_ext = 3'd1 + {1'b0, src_words};
            end
            mip_pkg::CLS_BIT_DYN, mip_pkg::CLS_MULDIV, mip_pkg::CLS_MOVE_SR,
            mip_pkg::CLS_CHK: begin
                o_ext = imm ? 3'd1 : {1'b0, src_words};
            end
            mip_pkg::CLS_IMM_OP: begin
                o_ext = (i_opcode[7] ? 3'd2 : 3'd1) + {1'b0, src_words};
            end
            mip_pkg::CLS_MOVE: begin
                o_ext = {1'b0, move_src} + {1'b0, dst_words};
            end
            mip_pkg::CLS_ADDR_OP: begin
                o_ext = imm ? (i_opcode[8] ? 3'd2 : 3'd1) : {1'b0, src_words};
            end
            mip_pkg::CLS_ALU: begin
                if (i_opcode[8] || !imm) begin
                    o_ext = {1'b0, src_words};
                end else begin
                    o_ext = i_opcode[7] ? 3'd2 : 3'd1;
                end
            end
            mip_pkg::CLS_SHIFT_MEM, mip_pkg::CLS_CMP_EOR, mip_pkg::CLS_SCC,
            mip_pkg::CLS_QUICK, mip_pkg::CLS_MOVE_FSR, mip_pkg::CLS_LEA,
            mip_pkg::CLS_TAS, mip_pkg::CLS_JUMP, mip_pkg::CLS_NBCD,
            mip_pkg::CLS_PEA, mip_pkg::CLS_UNARY: begin
                o_ext = {1'b0, src_words};
            end
            default: begin
                o_ext = 3'd0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- sv/m68k_instruction_predecode_unit.sv -----
// 68000 instruction predecode unit: class, extension length and next address.
// Depends on mip_pkg, mip_ifs, mip_classify and mip_ext_count.
//
// Usage:
//   i_req carries one opcode word and its 24-bit byte address per request;
//   o_rsp returns the instruction class (0..41, 41 for unmatched words),
//   the number of extension words (0..4) and the address of the next
//   instruction, wrapping at 24 bits. Both channels use valid/ready and a
//   request moves when both are high.
//   An input register feeds the table match and length logic, whose answer
//   lands in the result register together with the address sum. Throughput
//   is one request per cycle while o_rsp.ready stays high, set by the two
//   pipeline registers, each of which refills in the cycle it empties.
//   When the receiver holds o_rsp.ready low the result register keeps its
//   response, the input register fills behind it and then i_req.ready falls.
//   The synchronous active-low reset empties both registers; nothing else
//   holds state.
`default_nettype none

module m68k_instruction_predecode_unit (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    mip_req_if.sink     i_req,
    mip_rsp_if.source   o_rsp
);

    // Input stage registers
    logic            r_s1_valid;
    logic [15:0]     r_opcode;
    logic [23:0]     r_addr;

    // Result stage registers
    logic            r_out_valid;
    mip_pkg::t_class r_class;
    mip_pkg::t_ext   r_ext;
    logic [23:0]     r_next;

    logic            s1_ready;
    logic            s2_ready;
    mip_pkg::t_class cls;
    mip_pkg::t_ext   ext;
    logic [23:0]     n_next;

    // Stage readiness: a stage takes a request when empty or when it empties.
    assign s2_ready    = !r_out_valid || o_rsp.ready;
    assign s1_ready    = !r_s1_valid || s2_ready;
    assign i_req.ready = s1_ready;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= i_req.valid;
        end
        if (s1_ready && i_req.valid) begin
            r_opcode <= i_req.opcode_word;
            r_addr   <= i_req.instr_address;
        end
    end

    // Decode logic between the two registers.
    mip_classify u_classify (
        .i_opcode (r_opcode),
        .o_class  (cls)
    );

    mip_ext_count u_ext_count (
        .i_opcode (r_opcode),
        .i_class  (cls),
        .o_ext    (ext)
    );

    // Next address: two bytes of opcode plus two per extension word.
    assign n_next = r_addr + {20'd0, ext, 1'b0} + 24'd2;

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_ready) begin
            r_out_valid <= r_s1_valid;
        end
        if (s2_ready && r_s1_valid) begin
            r_class <= cls;
            r_ext   <= ext;
            r_next  <= n_next;
        end
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.instr_class     = r_class;
    assign o_rsp.extension_words = r_ext;
    assign o_rsp.next_address    = r_next;

    // The extension count never exceeds four words.
    a_ext_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_ext <= mip_pkg::MAX_EXT))
        else $error("extension word count out of range");

    // Unmatched opcode words carry no extension words.
    a_catch_all: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_class == mip_pkg::CLS_CATCH_ALL) |-> (r_ext == 3'd0))
        else $error("catch-all class with extension words");

    // A decoded request in the input stage reaches the result register.
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && s2_ready) |=> r_out_valid)
        else $error("decoded request lost between stages");

    // With nothing to hand on, a taken response leaves the result stage empty.
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_s1_valid && r_out_valid && o_rsp.ready) |=> !r_out_valid)
        else $error("response repeated after being taken");

    // With both stages full and the response stalled, the input claims no room.
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && !o_rsp.ready) |-> !i_req.ready)
        else $error("input taken while both stages are full and stalled");

endmodule

`default_nettype wire
